>>> hdl/boscmd_pkg.sv
// Shared types and constants for the bulk-only SCSI command handler.
// Holds command and result word layouts, action/response codes and opcodes.
// No dependencies.
package boscmd_pkg;

    localparam int unsigned MAX_CDB_LENGTH = 16;

    localparam logic [31:0] CBW_SIGNATURE = 32'h4342_5355;
    localparam logic [4:0]  FLAGS_RESERVED_MASK = 5'h1F;
    localparam logic [7:0]  SERIAL_PAGE_CODE = 8'h80;
    localparam logic [1:0]  EJECT_CODE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_NUM_BLOCKS = 1'b0;
    localparam logic CFG_BLOCK_SIZE = 1'b1;

    // SCSI opcodes
    localparam logic [7:0] OP_TEST_UNIT_READY  = 8'h00;
    localparam logic [7:0] OP_REQUEST_SENSE    = 8'h03;
    localparam logic [7:0] OP_FORMAT_UNIT      = 8'h04;
    localparam logic [7:0] OP_INQUIRY          = 8'h12;
    localparam logic [7:0] OP_MODE_SENSE6      = 8'h1A;
    localparam logic [7:0] OP_START_STOP       = 8'h1B;
    localparam logic [7:0] OP_SEND_DIAGNOSTIC  = 8'h1D;
    localparam logic [7:0] OP_PREVENT_REMOVAL  = 8'h1E;
    localparam logic [7:0] OP_READ_FORMAT_CAPS = 8'h23;
    localparam logic [7:0] OP_READ_CAPACITY10  = 8'h25;
    localparam logic [7:0] OP_READ10           = 8'h28;
    localparam logic [7:0] OP_WRITE10          = 8'h2A;
    localparam logic [7:0] OP_VERIFY10         = 8'h2F;
    localparam logic [7:0] OP_SYNC_CACHE       = 8'h35;

    // Sense keys
    localparam logic [3:0] SK_NO_SENSE       = 4'h0;
    localparam logic [3:0] SK_NOT_READY      = 4'h2;
    localparam logic [3:0] SK_MEDIUM_ERROR   = 4'h3;
    localparam logic [3:0] SK_ILLEGAL_REQ    = 4'h5;
    localparam logic [3:0] SK_DATA_PROTECT   = 4'h7;

    // Additional sense codes
    localparam logic [7:0] ASC_NONE          = 8'h00;
    localparam logic [7:0] ASC_WRITE_FAULT   = 8'h03;
    localparam logic [7:0] ASC_UNRECOV_READ  = 8'h11;
    localparam logic [7:0] ASC_INVALID_OPCODE = 8'h20;
    localparam logic [7:0] ASC_LBA_RANGE     = 8'h21;
    localparam logic [7:0] ASC_INVALID_FIELD = 8'h24;
    localparam logic [7:0] ASC_WRITE_PROTECT = 8'h27;
    localparam logic [7:0] ASC_NO_MEDIUM     = 8'h3A;

    typedef enum logic [2:0] {
        ACT_STALL_BOTH   = 3'd0,
        ACT_STALL_IN     = 3'd1,
        ACT_STATUS       = 3'd2,
        ACT_DATA_STATUS  = 3'd3,
        ACT_READ         = 3'd4,
        ACT_WRITE        = 3'd5,
        ACT_STALL_STATUS = 3'd6,
        ACT_DISCONNECTED = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        RSP_NONE         = 3'd0,
        RSP_INQUIRY      = 3'd1,
        RSP_SERIAL_PAGE  = 3'd2,
        RSP_SENSE        = 3'd3,
        RSP_READ_CAP     = 3'd4,
        RSP_MODE_SENSE   = 3'd5,
        RSP_FORMAT_CAPS  = 3'd6
    } t_rsp_kind;

    typedef struct packed {
        logic [31:0] signature;
        logic [7:0]  lun;
        logic [31:0] data_length;
        logic [7:0]  direction_flags;
        logic [4:0]  cdb_length;
        logic [7:0]  opcode;
        logic [7:0]  cdb_byte_one;
        logic [31:0] lba_field;
        logic [15:0] transfer_blocks;
        logic [7:0]  cdb_byte_four;
        logic [31:0] tag;
        logic [2:0]  media_status;
    } t_cmd;

    typedef struct packed {
        t_action     action;
        t_rsp_kind   response_kind;
        logic [31:0] start_block;
        logic [15:0] block_total;
        logic [31:0] capacity_value;
        logic        status_code;
        logic [31:0] residue;
        logic [31:0] echo_tag;
        logic [3:0]  reported_sense_key;
        logic [7:0]  reported_sense_code;
        logic        ejected_flag;
    } t_result;

    // Unit state as seen by the decoder, and its update
    typedef struct packed {
        logic [3:0] sense_key;
        logic [7:0] sense_code;
        logic       ejected;
    } t_unit_state;

    typedef struct packed {
        logic       sense_we;
        logic [3:0] sense_key;
        logic [7:0] sense_code;
        logic       set_ejected;
    } t_state_upd;

endpackage

>>> hdl/boscmd_decode.sv
// Combinational command wrapper check and SCSI opcode decode.
// Depends on boscmd_pkg.
module boscmd_decode
    import boscmd_pkg::*;
(
    input  t_cmd        i_cmd,
    input  logic [31:0] i_num_blocks,
    input  t_unit_state i_state,
    output t_result     o_result,
    output t_state_upd  o_upd
);

    logic       w_present;
    logic       w_wprot;
    logic       w_mfail;
    logic       w_bad_wrapper;
    logic       w_known;
    logic       w_pass;
    logic       w_eject_req;
    logic [3:0] w_key;
    logic [7:0] w_code;
    logic       w_lba_out;
    t_action    w_action;
    t_rsp_kind  w_kind;
    logic [31:0] w_cap;
    logic       w_xfer;

    assign w_present = i_cmd.media_status[0];
    assign w_wprot   = i_cmd.media_status[1];
    assign w_mfail   = i_cmd.media_status[2];
    assign w_lba_out = (i_cmd.lba_field >= i_num_blocks);

    assign w_bad_wrapper = (i_cmd.signature != CBW_SIGNATURE) || (i_cmd.lun != 8'd0)
        || ((i_cmd.data_length != 32'd0)
            && ((i_cmd.direction_flags[4:0] & FLAGS_RESERVED_MASK) != 5'd0))
        || (i_cmd.cdb_length == 5'd0) || (i_cmd.cdb_length > 5'(MAX_CDB_LENGTH));

    // Opcode decode: produces the pass-path answer and the failure sense.
    always_comb begin
        w_known     = 1'b1;
        w_pass      = 1'b1;
        w_key       = SK_NO_SENSE;
        w_code      = ASC_NONE;
        w_action    = ACT_STATUS;
        w_kind      = RSP_NONE;
        w_cap       = 32'd0;
        w_xfer      = 1'b0;
        w_eject_req = 1'b0;
        unique case (i_cmd.opcode)
            OP_INQUIRY: begin
                if (i_cmd.cdb_byte_one[0]) begin
                    if (i_cmd.lba_field[31:24] == SERIAL_PAGE_CODE) begin
                        w_kind   = RSP_SERIAL_PAGE;
                        w_action = ACT_DATA_STATUS;
                    end else begin
                        w_pass = 1'b0;
                        w_key  = SK_ILLEGAL_REQ;
                        w_code = ASC_INVALID_FIELD;
                    end
                end else begin
                    w_kind   = RSP_INQUIRY;
                    w_action = ACT_DATA_STATUS;
                end
            end
            OP_REQUEST_SENSE: begin
                w_kind   = RSP_SENSE;
                w_action = ACT_DATA_STATUS;
            end
            OP_READ_CAPACITY10: begin
                w_kind   = RSP_READ_CAP;
                w_action = ACT_DATA_STATUS;
                w_cap    = i_num_blocks - 32'd1;
            end
            OP_MODE_SENSE6: begin
                w_kind   = RSP_MODE_SENSE;
                w_action = ACT_DATA_STATUS;
            end
            OP_READ_FORMAT_CAPS: begin
                w_kind   = RSP_FORMAT_CAPS;
                w_action = ACT_DATA_STATUS;
                w_cap    = i_num_blocks;
            end
            OP_READ10: begin
                if (w_lba_out) begin
                    w_pass = 1'b0;
                    w_key  = SK_ILLEGAL_REQ;
                    w_code = ASC_LBA_RANGE;
                end else if (w_mfail) begin
                    w_pass = 1'b0;
                    w_key  = SK_MEDIUM_ERROR;
                    w_code = ASC_UNRECOV_READ;
                end else begin
                    w_action = ACT_READ;
                    w_xfer   = 1'b1;
                end
            end
            OP_WRITE10: begin
                if (w_wprot) begin
                    w_pass = 1'b0;
                    w_key  = SK_DATA_PROTECT;
                    w_code = ASC_WRITE_PROTECT;
                end else if (w_lba_out) begin
                    w_pass = 1'b0;
                    w_key  = SK_ILLEGAL_REQ;
                    w_code = ASC_LBA_RANGE;
                end else if (w_mfail && (i_cmd.transfer_blocks != 16'd0)) begin
                    w_pass = 1'b0;
                    w_key  = SK_MEDIUM_ERROR;
                    w_code = ASC_WRITE_FAULT;
                end else begin
                    w_action = ACT_WRITE;
                    w_xfer   = 1'b1;
                end
            end
            OP_SEND_DIAGNOSTIC: begin
                if (!i_cmd.cdb_byte_one[2]) begin
                    w_pass = 1'b0;
                    w_key  = SK_ILLEGAL_REQ;
                    w_code = ASC_INVALID_FIELD;
                end
            end
            OP_START_STOP: begin
                w_eject_req = (i_cmd.cdb_byte_four[1:0] == EJECT_CODE);
            end
            OP_TEST_UNIT_READY: begin
                if (!w_present) begin
                    w_pass = 1'b0;
                    w_key  = SK_NOT_READY;
                    w_code = ASC_NO_MEDIUM;
                end
            end
            OP_FORMAT_UNIT, OP_PREVENT_REMOVAL, OP_VERIFY10: begin
            end
            OP_SYNC_CACHE: begin
                if (w_mfail) begin
                    w_pass = 1'b0;
                    w_key  = SK_MEDIUM_ERROR;
                    w_code = ASC_WRITE_FAULT;
                end
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    // Final answer with ejected / bad wrapper / unknown / failed overrides
    always_comb begin
        o_result                     = '0;
        o_result.echo_tag            = i_cmd.tag;
        o_result.reported_sense_key  = i_state.sense_key;
        o_result.reported_sense_code = i_state.sense_code;
        o_result.ejected_flag        = i_state.ejected;
        o_result.action              = ACT_STATUS;
        o_result.response_kind       = RSP_NONE;
        o_upd                        = '0;
        if (i_state.ejected) begin
            o_result.action = ACT_DISCONNECTED;
        end else if (w_bad_wrapper) begin
            o_result.action = ACT_STALL_BOTH;
        end else if (!w_known) begin
            o_result.action  = ACT_STALL_IN;
            o_upd.sense_we   = 1'b1;
            o_upd.sense_key  = SK_ILLEGAL_REQ;
            o_upd.sense_code = ASC_INVALID_OPCODE;
        end else begin
            o_upd.sense_we    = 1'b1;
            o_upd.sense_key   = w_key;
            o_upd.sense_code  = w_code;
            o_upd.set_ejected = w_eject_req;
            o_result.ejected_flag = w_eject_req;
            if (w_pass) begin
                o_result.action         = w_action;
                o_result.response_kind  = w_kind;
                o_result.capacity_value = w_cap;
                o_result.start_block    = w_xfer ? i_cmd.lba_field : 32'd0;
                o_result.block_total    = w_xfer ? i_cmd.transfer_blocks : 16'd0;
            end else begin
                o_result.action      = (i_cmd.data_length != 32'd0) ? ACT_STALL_STATUS
                                                                    : ACT_STATUS;
                o_result.status_code = 1'b1;
                o_result.residue     = i_cmd.data_length;
            end
        end
    end

endmodule

>>> hdl/bulk_only_scsi_command_handler.sv
// Top level of the bulk-only SCSI command handler: input register, decoder,
// result register, unit state and configuration. Depends on boscmd_pkg and
// boscmd_decode.
//
//  channel | valid       | ready       | payload  | dir
//  --------+-------------+-------------+----------+-----
//  command | i_in_valid  | o_in_ready  | i_in     | in
//  result  | o_out_valid | i_out_ready | o_out    | out
//  config  | i_cfg_we    | (none)      | i_cfg_index, i_cfg_data | in
//
// One word per cycle sustained while i_out_ready is high (input register, then
// decode into the result register). The input register advances whenever the
// result register is empty or being taken, so a stall on the result side
// backs up through o_in_ready only after both registers hold a word.
// Synchronous active-low reset clears valids, sense (0/0), ejected flag and
// sets the medium size to one block.
module bulk_only_scsi_command_handler
    import boscmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_cmd        i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic        r_s1_valid;
    t_cmd        r_s1_cmd;
    logic        r_out_valid;
    t_result     r_out;
    logic [31:0] r_num_blocks;
    logic [3:0]  r_sense_key;
    logic [7:0]  r_sense_code;
    logic        r_ejected;

    logic        w_s1_adv;   // stage-1 word moves into the result register
    logic        w_in_take;
    t_unit_state w_state;
    t_result     w_result;
    t_state_upd  w_upd;

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_in_take  = i_in_valid && o_in_ready;

    assign w_state.sense_key  = r_sense_key;
    assign w_state.sense_code = r_sense_code;
    assign w_state.ejected    = r_ejected;

    boscmd_decode u_decode (
        .i_cmd         (r_s1_cmd),
        .i_num_blocks  (r_num_blocks),
        .i_state       (w_state),
        .o_result      (w_result),
        .o_upd         (w_upd)
    );

    // Control: valids, unit state, config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_num_blocks  <= 32'd1;
            r_sense_key   <= SK_NO_SENSE;
            r_sense_code  <= ASC_NONE;
            r_ejected     <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // State changes commit as the word leaves decode, in command order
            if (w_s1_adv && w_upd.sense_we) begin
                r_sense_key  <= w_upd.sense_key;
                r_sense_code <= w_upd.sense_code;
            end
            if (w_s1_adv && w_upd.set_ejected) begin
                r_ejected <= 1'b1;
            end
            // Block size only feeds the capacity payload bytes, not built here
            if (i_cfg_we && (i_cfg_index == CFG_NUM_BLOCKS)) begin
                r_num_blocks <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_cmd <= i_in;
        end
        if (w_s1_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_eject_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ejected |=> r_ejected)
        else $error("ejected flag cleared");

    a_disc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.action == ACT_DISCONNECTED)) |-> o_out.ejected_flag)
        else $error("disconnected answer without ejected flag");

    a_fail_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status_code) |->
        ((o_out.action == ACT_STATUS) || (o_out.action == ACT_STALL_STATUS)))
        else $error("failed status with wrong action");

    a_xfer_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out.action == ACT_READ) || (o_out.action == ACT_WRITE)))
        |-> (!o_out.status_code && (o_out.residue == 32'd0)))
        else $error("transfer answer carries failure");
`endif

endmodule
